// ===== rtl/fscs_pkg.sv =====
// shared types and constants for the falling sand column step block
// no dependencies; imported by every module of the block
package fscs_pkg;

    localparam int CELLS_W           = 64;
    localparam int COLUMN_HEIGHT_DEF = 64;

    // most beats one column can release (frame end of a long frame)
    localparam int MAX_PUSH   = 3;
    localparam int PUSH_CNT_W = 2;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CELLS_W-1:0] next_cells;
        logic               frame_last;
    } fscs_result_t;

    // results released by one accepted column, packed from slot 0 up
    typedef struct packed {
        logic [PUSH_CNT_W-1:0] cnt;
        fscs_result_t [MAX_PUSH-1:0] slot;
    } fscs_push_t;

endpackage

// ===== rtl/fscs_land.sv =====
// next-generation column for one centre column from its neighbors
// depends on fscs_pkg; purely combinational, bitwise across rows
module fscs_land
    import fscs_pkg::*;
#(
    parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
)
(
    input  logic [COLUMN_HEIGHT-1:0] left,
    input  logic                     left_ok,
    input  logic [COLUMN_HEIGHT-1:0] centre,
    input  logic [COLUMN_HEIGHT-1:0] right,
    input  logic                     right_ok,
    input  logic [COLUMN_HEIGHT-1:0] far,
    input  logic                     far_ok,
    output logic [COLUMN_HEIGHT-1:0] result
);

    localparam logic [COLUMN_HEIGHT-1:0] GROUND = {1'b1, {(COLUMN_HEIGHT-1){1'b0}}};

    logic [COLUMN_HEIGHT-1:0] bl, br, bf;
    logic [COLUMN_HEIGHT-1:0] air, down, rest, stay;
    logic [COLUMN_HEIGHT-1:0] dr, dl;

    always_comb
    begin
        // missing neighbors block every move into them
        bl = left_ok  ? left  : '1;
        br = right_ok ? right : '1;
        bf = far_ok   ? far   : '1;

        air  = centre & ~GROUND;
        down = air & ~(centre >> 1);
        rest = air & (centre >> 1) & (br >> 1);
        stay = (centre & GROUND) | (rest & (bl >> 1));

        // left grains sliding down-right into this column
        dr = left_ok ? (left & ~GROUND & (left >> 1) & ~(centre >> 1)) : '0;
        // right grains sliding down-left, only when their own down-right is taken
        dl = right_ok ? (right & ~GROUND & (right >> 1) & (bf >> 1) & ~(centre >> 1)) : '0;

        result = stay | ((down | dr | dl) << 1);
    end

endmodule

// ===== rtl/fscs_window.sv =====
// column window, frame tracking and the three land units
// depends on fscs_pkg and fscs_land
module fscs_window
    import fscs_pkg::*;
#(
    parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [CELLS_W-1:0] cells,
    input  logic               frame_start,
    input  logic               frame_end,
    output fscs_push_t         push
);

    logic [COLUMN_HEIGHT-1:0] w0_reg, w1_reg, w2_reg;
    logic [COLUMN_HEIGHT-1:0] w0_next, w1_next, w2_next;
    logic [1:0]               seen_reg, seen_next;

    logic [COLUMN_HEIGHT-1:0] col;
    logic [1:0]               seen;
    logic                     v0, v1;
    logic [COLUMN_HEIGHT-1:0] r0, r1, r2;
    fscs_result_t             res0, res1, res2;

    assign col  = cells[COLUMN_HEIGHT-1:0];
    assign seen = frame_start ? 2'd0 : seen_reg;
    assign v0   = (seen >= 2'd2);
    assign v1   = frame_end && (seen >= 2'd1);

    // column two back, released when its right-right neighbor arrives
    fscs_land #(.COLUMN_HEIGHT(COLUMN_HEIGHT)) u_land0 (
        .left(w2_reg), .left_ok(seen == 2'd3),
        .centre(w1_reg),
        .right(w0_reg), .right_ok(1'b1),
        .far(col), .far_ok(1'b1),
        .result(r0)
    );

    // flush: newest held column, no far neighbor
    fscs_land #(.COLUMN_HEIGHT(COLUMN_HEIGHT)) u_land1 (
        .left(w1_reg), .left_ok(seen >= 2'd2),
        .centre(w0_reg),
        .right(col), .right_ok(1'b1),
        .far('0), .far_ok(1'b0),
        .result(r1)
    );

    // flush: the incoming last column itself
    fscs_land #(.COLUMN_HEIGHT(COLUMN_HEIGHT)) u_land2 (
        .left(w0_reg), .left_ok(seen >= 2'd1),
        .centre(col),
        .right('0), .right_ok(1'b0),
        .far('0), .far_ok(1'b0),
        .result(r2)
    );

    always_comb
    begin
        res0 = '{next_cells: CELLS_W'(r0), frame_last: 1'b0};
        res1 = '{next_cells: CELLS_W'(r1), frame_last: 1'b0};
        res2 = '{next_cells: CELLS_W'(r2), frame_last: 1'b1};

        // compact valid results into the low slots, in order
        push.slot[0] = v0 ? res0 : (v1 ? res1 : res2);
        push.slot[1] = v0 ? res1 : res2;
        push.slot[2] = res2;
        if (!accept)
        begin
            push.cnt = '0;
        end
        else
        begin
            push.cnt = PUSH_CNT_W'(v0) + PUSH_CNT_W'(v1) + PUSH_CNT_W'(frame_end);
        end
    end

    always_comb
    begin
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                seen_next = 2'd0;
            end
            else
            begin
                w2_next   = w1_reg;
                w1_next   = w0_reg;
                w0_next   = col;
                seen_next = (seen == 2'd3) ? 2'd3 : seen + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 2'd0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // window contents are only read under the column count
    always_ff @(posedge clk)
    begin
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
    end

endmodule

// ===== rtl/fscs_queue.sv =====
// result queue: takes up to three results per cycle, gives one beat per cycle while pop is high
// depends on fscs_pkg
module fscs_queue
    import fscs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fscs_push_t   push,
    input  logic         pop,
    output logic         room,
    output logic         valid,
    output fscs_result_t head
);

    fscs_result_t             q_reg  [QUEUE_DEPTH];
    fscs_result_t             q_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         cnt_pop;

    assign valid = (cnt_reg != '0);
    assign head  = q_reg[0];
    // a whole frame-end burst must fit whatever the receiver does
    assign room  = (cnt_reg <= CNT_W'(QUEUE_DEPTH - MAX_PUSH));

    always_comb
    begin
        logic [CNT_W-1:0] off;
        cnt_pop = cnt_reg - CNT_W'(pop && valid);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            off = CNT_W'(i) - cnt_pop;
            if ((CNT_W'(i) >= cnt_pop) && (off < CNT_W'(push.cnt)))
            begin
                q_next[i] = push.slot[off[PUSH_CNT_W-1:0]];
            end
        end
        cnt_next = cnt_pop + CNT_W'(push.cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// ===== rtl/falling_sand_column_step.sv =====
// top level of the falling sand column step block
// depends on fscs_pkg, fscs_window, fscs_land and fscs_queue
//
// one generation of a falling sand grid, streamed one column per beat
// slave side: s_tdata carries one grid column (bit y = row y, row 0 at top,
//   row COLUMN_HEIGHT-1 is the ground), s_tuser marks the first column of a
//   frame and s_tlast the last column
// master side: m_tdata carries one next-generation column, m_tlast marks
//   the last column of the frame
// a column is decided when the column two to its right arrives, so output
//   lags the input by two columns; the last column of a frame flushes the
//   held columns, up to two, plus itself as a burst of up to three beats
// a released result is written into the result queue registers and reaches
//   the master side from there, behind any beats still waiting
// throughput: one column per cycle in the body of a frame while the receiver
//   is ready; a frame end releases up to three beats and the slave side
//   then pauses while the four entry result queue drains
// s_tready is high while at most one beat waits, so a full frame-end burst
//   always fits; a stalled receiver holds off the input once two beats wait
// reset clears the column count and the queue; no beat is pending after it
// a column after reset or after a frame end starts a new frame by itself
module falling_sand_column_step
    import fscs_pkg::*;
#(
    parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CELLS_W-1:0] s_tdata,   // cells
    input  logic               s_tuser,   // frame_start
    input  logic               s_tlast,   // frame_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CELLS_W-1:0] m_tdata,   // next_cells
    output logic               m_tlast    // frame_last
);

    logic         accept;
    logic         room;
    fscs_push_t   push;
    fscs_result_t head;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // window of held columns and the land logic for up to three results
    fscs_window #(.COLUMN_HEIGHT(COLUMN_HEIGHT)) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cells       (s_tdata),
        .frame_start (s_tuser),
        .frame_end   (s_tlast),
        .push        (push)
    );

    // result registers, one beat per cycle toward the receiver while it is ready
    fscs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (m_tready),
        .room  (room),
        .valid (m_tvalid),
        .head  (head)
    );

    assign m_tdata = head.next_cells;
    assign m_tlast = head.frame_last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the falling sand column step block
// depends on fscs_pkg and falling_sand_column_step; runs stand-alone
module tb_top;
    import fscs_pkg::*;

    localparam int COL_H = COLUMN_HEIGHT_DEF;
    localparam logic [CELLS_W-1:0] ROW_MASK = {CELLS_W{1'b1}} >> (CELLS_W - COL_H);
    localparam logic [CELLS_W-1:0] GROUND_ROW = {{(CELLS_W-1){1'b0}}, 1'b1} << (COL_H - 1);
    localparam logic [CELLS_W-1:0] BLOCKED = {CELLS_W{1'b1}};
    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM = 350;

    // one directed beat: column, frame flags and, where obvious, the single result
    typedef struct packed {
        logic [CELLS_W-1:0] cells;
        logic               fs;
        logic               fe;
        logic               typed;
        logic [CELLS_W-1:0] exp_cells;
        logic               exp_last;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [CELLS_W-1:0] s_tdata;   // cells
    logic               s_tuser;   // frame_start
    logic               s_tlast;   // frame_end
    logic               m_tvalid;
    logic               m_tready;
    logic [CELLS_W-1:0] m_tdata;   // next_cells
    logic               m_tlast;   // frame_last

    // predictor state: the last four columns, newest first, and how many are held
    logic [CELLS_W-1:0] held_cols [0:3];
    int                 held_count;
    fscs_result_t       released [0:MAX_PUSH-1];
    int                 released_n;

    fscs_result_t       pending_cols [$];
    fscs_result_t       oldest;
    stim_row_t          directed_rows [0:N_DIRECTED-1];
    int                 errors;
    bit                 calm;

    falling_sand_column_step uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    // next-generation column for centre; an invalid neighbor holds no grain
    // and blocks every move into it
    function automatic logic [CELLS_W-1:0] fall_into(
        input logic [CELLS_W-1:0] left, input logic lv,
        input logic [CELLS_W-1:0] centre,
        input logic [CELLS_W-1:0] right, input logic rv,
        input logic [CELLS_W-1:0] far, input logic fv);
        logic [CELLS_W-1:0] bl, br, bf, g, air, down, rest, stay, res, mover;
        bl = lv ? left : BLOCKED;
        br = rv ? right : BLOCKED;
        bf = fv ? far : BLOCKED;
        g = centre & ROW_MASK;
        air = g & ~GROUND_ROW;
        down = air & ~(centre >> 1);
        // blocked below, then blocked down-right, then blocked down-left: stays
        rest = air & (centre >> 1) & (br >> 1) & (bl >> 1);
        stay = (g & GROUND_ROW) | rest;
        res = stay | (down << 1);
        if (lv)
        begin
            // left neighbor grains sliding down-right into this column
            mover = left & ROW_MASK & ~GROUND_ROW & (left >> 1) & ~(centre >> 1);
            res |= mover << 1;
        end
        if (rv)
        begin
            // right neighbor grains sliding down-left, only when down-right is blocked
            mover = right & ROW_MASK & ~GROUND_ROW & (right >> 1) & (bf >> 1)
                    & ~(centre >> 1);
            res |= mover << 1;
        end
        return res & ROW_MASK;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < 4; i++)
            held_cols[i] = '0;
        held_count = 0;
    endfunction

    // one accepted column: fills released[] with the columns it lets out
    function automatic void advance_grid(input logic [CELLS_W-1:0] raw,
                                         input logic fs, input logic fe);
        logic [CELLS_W-1:0] cells;
        int seen;
        cells = raw & ROW_MASK;
        released_n = 0;
        if (fs)
            clear_window();
        seen = held_count;
        if (seen >= 2)
        begin
            released[released_n] = '{fall_into(held_cols[2], seen == 3, held_cols[1],
                                                held_cols[0], 1'b1, cells, 1'b1), 1'b0};
            released_n++;
        end
        if (fe)
        begin
            // frame end flushes the columns still waiting, up to two, plus this one
            if (seen >= 1)
            begin
                released[released_n] = '{fall_into(held_cols[1], seen >= 2, held_cols[0],
                                                    cells, 1'b1, '0, 1'b0), 1'b0};
                released_n++;
            end
            released[released_n] = '{fall_into(held_cols[0], seen >= 1, cells,
                                                '0, 1'b0, '0, 1'b0), 1'b1};
            released_n++;
            clear_window();
        end
        else
        begin
            held_cols[3] = held_cols[2];
            held_cols[2] = held_cols[1];
            held_cols[1] = held_cols[0];
            held_cols[0] = cells;
            if (held_count < 3)
                held_count++;
        end
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [CELLS_W-1:0] rand_column();
        logic [CELLS_W-1:0] a, b, c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: return a;
            3, 4:    return a & b & c;     // sparse sand
            5, 6:    return a | b;         // dense pile
            7:       return '0;
            8:       return BLOCKED;
            default: return {{(CELLS_W-1){1'b0}}, 1'b1} << $urandom_range(0, CELLS_W-1);
        endcase
    endfunction

    function automatic stim_row_t stim_row(input logic [CELLS_W-1:0] cells,
                                           input logic fs, input logic fe,
                                           input logic typed,
                                           input logic [CELLS_W-1:0] exp_cells);
        return {cells, fs, fe, typed, exp_cells, 1'b1};
    endfunction

    // offer one column beat, called at a rising edge, returns at the accepting edge
    task automatic put_column(input logic [CELLS_W-1:0] cells, input logic fs,
                              input logic fe, input logic typed,
                              input logic [CELLS_W-1:0] exp_cells, input logic exp_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tuser  <= fs;
        s_tlast  <= fe;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_grid(cells, fs, fe);
        if (typed)
            pending_cols.push_back('{exp_cells, exp_last});
        else
            for (int i = 0; i < released_n; i++)
                pending_cols.push_back(released[i]);
    endtask

    // hold the sender off until every expected column has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_cols.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // receiver: random stalls, with long stretches of steady ready
    initial
    begin : receiver
        int n;
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 200)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // result checker: every output beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cols.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual next_cells %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                oldest = pending_cols.pop_front();
                if (m_tdata !== oldest.next_cells)
                begin
                    errors++;
                    $display("%0t: next_cells expected %h actual %h",
                             $time, oldest.next_cells, m_tdata);
                end
                if (m_tlast !== oldest.frame_last)
                begin
                    errors++;
                    $display("%0t: frame_last expected %b actual %b",
                             $time, oldest.frame_last, m_tlast);
                end
            end
        end
    end

    initial
    begin : stimulus
        int random_sent;
        int frames;
        int len;
        int r;
        bit open_start;
        bit drop_end;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        errors   = 0;
        calm     = 1'b0;
        clear_window();

        // single-column frames: results are read straight off the fall rules
        directed_rows[0]  = stim_row('0, 1, 1, 1, '0);                // empty after reset
        directed_rows[1]  = stim_row(BLOCKED, 1, 1, 1, BLOCKED);      // full column holds
        directed_rows[2]  = stim_row(64'h1, 1, 1, 1, 64'h2);          // top grain falls one row
        directed_rows[3]  = stim_row(GROUND_ROW, 1, 1, 1, GROUND_ROW); // grain on ground stays
        directed_rows[4]  = stim_row(64'h1, 0, 1, 1, 64'h2);          // no frame start flag
        // two-column frame
        directed_rows[5]  = stim_row(64'h3, 1, 0, 0, '0);
        directed_rows[6]  = stim_row(64'h1, 0, 1, 0, '0);
        // long frame; first three columns make two grains merge on one cell
        directed_rows[7]  = stim_row(64'h3, 1, 0, 0, '0);
        directed_rows[8]  = stim_row(64'h1, 0, 0, 0, '0);
        directed_rows[9]  = stim_row(64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, '0);
        directed_rows[10] = stim_row(64'h5555_5555_5555_5555, 0, 0, 0, '0);
        directed_rows[11] = stim_row(BLOCKED, 0, 0, 0, '0);
        directed_rows[12] = stim_row('0, 0, 1, 0, '0);
        // restart inside a frame drops the unfinished columns
        directed_rows[13] = stim_row(64'hF0F0_F0F0_F0F0_F0F0, 1, 0, 0, '0);
        directed_rows[14] = stim_row(64'h0F0F_0F0F_0F0F_0F0F, 0, 0, 0, '0);
        directed_rows[15] = stim_row(64'h1234_5678_9ABC_DEF0, 0, 0, 0, '0);
        directed_rows[16] = stim_row(64'hFFFF_0000_FFFF_0000, 1, 0, 0, '0);
        directed_rows[17] = stim_row(64'h8000_0000_0000_0001, 0, 0, 0, '0);
        directed_rows[18] = stim_row(64'h7FFF_FFFF_FFFF_FFFE, 0, 1, 0, '0);
        // three-column frame opened without a start flag
        directed_rows[19] = stim_row(64'hDEAD_BEEF_0BAD_F00D, 0, 0, 0, '0);
        directed_rows[20] = stim_row(64'h0123_4567_89AB_CDEF, 0, 0, 0, '0);
        directed_rows[21] = stim_row(64'hC3C3_3C3C_A5A5_5A5A, 0, 1, 0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            put_column(directed_rows[i].cells, directed_rows[i].fs, directed_rows[i].fe,
                       directed_rows[i].typed, directed_rows[i].exp_cells,
                       directed_rows[i].exp_last);
        drain_results();

        // random frames: mostly well formed, some without start or end,
        // a few restarted halfway
        random_sent = 0;
        frames = 0;
        while (random_sent < N_RANDOM)
        begin
            if ($urandom_range(0, 99) < 15)
                calm = ~calm;
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 1;
            else if (r < 20)
                len = 2;
            else if (r < 92)
                len = $urandom_range(3, 10);
            else
                len = $urandom_range(11, 40);
            open_start = ($urandom_range(0, 9) != 0);
            drop_end = ($urandom_range(0, 11) == 0);
            for (int i = 0; i < len; i++)
            begin
                put_column(rand_column(),
                           (i == 0) ? open_start : ($urandom_range(0, 39) == 0),
                           (i == len - 1) && !drop_end, 1'b0, '0, 1'b0);
                random_sent++;
            end
            frames++;
            if (frames == 12)
                drain_results();
        end

        // all columns sent: wait for the last beats, then a margin for strays
        s_tvalid <= 1'b0;
        while (pending_cols.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fscs_pkg.sv
rtl/fscs_land.sv
rtl/fscs_window.sv
rtl/fscs_queue.sv
rtl/falling_sand_column_step.sv
tb/tb_top.sv
